@@ rtl/dqds_pkg.sv @@
// ----------------------------------------------------------------------------
// dqds_pkg
// Shared types, codes and the quadrature step table for the dual quadrature
// decoder with speed meter.
// ----------------------------------------------------------------------------
package dqds_pkg;

  // Item kinds carried in the input tuser
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_HOLD   = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LEFT_CPM  = 2'd0,
    CFG_RIGHT_CPM = 2'd1,
    CFG_LEFT_REV  = 2'd2,
    CFG_RIGHT_REV = 2'd3
  } cfg_idx_e;

  // Count change from one phase pair
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_LOAD  = 3'd1,
    ST_MUL   = 3'd2,
    ST_DIV   = 3'd3,
    ST_STORE = 3'd4,
    ST_EMIT  = 3'd5
  } state_e;

  localparam int unsigned CpmBits  = 24;
  localparam int unsigned SpeedBits = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // non-tick item accepted: apply it
    logic load;      // load the speed unit for the selected wheel
    logic mul_step;  // one shift-add step of delta times scale
    logic div_step;  // one restoring division step
    logic store;     // saturate and store the selected wheel's speed
    logic finish;    // take window snapshots, emit the tick result
    logic side;      // 0 left wheel, 1 right wheel
  } cmd_t;

  // One result item; done sits on top and travels as tuser
  typedef struct packed {
    logic        done;
    logic [31:0] mean_pos;
    logic [31:0] right_speed;
    logic [31:0] left_speed;
    logic [31:0] right_pos;
    logic [31:0] left_pos;
  } res_t;

  // 4x decode: previous A:B in the upper pair, current A:B in the lower pair
  function automatic step_e step_of(input logic [1:0] prev, input logic [1:0] cur);
    step_e s;
    unique case ({prev, cur})
      4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_UP;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_DOWN;
      default:                            s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/dual_quadrature_decoder_speed.sv @@
// ----------------------------------------------------------------------------
// dual_quadrature_decoder_speed
// Two-wheel 4x quadrature decoder with position counters and a speed meter.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser[1:0] is the item kind (pin sample, window tick,
//   clear, hold); tdata carries the four encoder levels. Every input
//   transaction yields exactly one output transaction: both positions, both
//   speeds in mm/s, their mean in tdata and the window-done flag in tuser.
//   Pin samples, clears and holds yield a registered result, and a new item
//   is taken every cycle while the output drains. A window tick runs one
//   shared shift-add multiplier and one restoring divider over both wheels
//   in turn, and no input is taken meanwhile.
//   A stalled output holds its result; one more result parks in a skid
//   register, after which tready drops until the output drains.
//   Reset clears counts, phases, snapshots and speeds, and loads 6896 counts
//   per metre and no reversal. Configuration writes are always ready and
//   must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module dual_quadrature_decoder_speed import dqds_pkg::*; #(
  parameter int unsigned COUNT_BITS   = 32,
  parameter int unsigned WINDOW_SCALE = 100000
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // left_phase_a, left_phase_b, right_phase_a,
                                         // right_phase_b, zero padding
  input  logic [1:0]   s_axis_tuser_i,   // op
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [159:0] m_axis_tdata_o,   // left_position, right_position,
                                         // left_speed_mms, right_speed_mms, mean_position
  output logic [0:0]   m_axis_tuser_o,   // window_done
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  cmd_t cmd;
  res_t res, out_res;
  logic out_free;
  op_e  op;

  assign op          = op_e'(s_axis_tuser_i);
  assign cfg_ready_o = 1'b1;

  dqds_ctrl #(
    .COUNT_BITS   (COUNT_BITS),
    .WINDOW_SCALE (WINDOW_SCALE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (op),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  dqds_datapath #(
    .COUNT_BITS   (COUNT_BITS),
    .WINDOW_SCALE (WINDOW_SCALE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .op_i        (op),
    .phase_i     (s_axis_tdata_i[3:0]),
    .cmd_i       (cmd),
    .res_o       (res)
  );

  dqds_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd.take || cmd.finish),
    .data_i      (res),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata_o = {out_res.mean_pos, out_res.right_speed, out_res.left_speed,
                           out_res.right_pos, out_res.left_pos};
  assign m_axis_tuser_o = out_res.done;

endmodule

@@ rtl/dqds_ctrl.sv @@
// ----------------------------------------------------------------------------
// dqds_ctrl
// Sequencer: accepts items, and for a window tick runs the shared speed unit
// over the left and then the right wheel before emitting the result.
// ----------------------------------------------------------------------------
module dqds_ctrl import dqds_pkg::*; #(
  parameter int unsigned COUNT_BITS   = 32,
  parameter int unsigned WINDOW_SCALE = 100000
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  op_e  in_op_i,
  output logic in_ready_o,
  input  logic out_free_i,
  output cmd_t cmd_o
);

  localparam int unsigned ScaleBits = $clog2(WINDOW_SCALE + 1);
  localparam int unsigned ProdBits  = COUNT_BITS + ScaleBits;
  localparam int unsigned CntW      = $clog2(ProdBits);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            side_q, side_d;
  logic            accept;

  assign accept = in_valid_i && in_ready_o;

  // State, step counter and wheel select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      side_q  <= side_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    side_d     = side_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.side = side_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free_i;
        if (accept) begin
          if (in_op_i == OP_TICK) begin
            side_d  = 1'b0;
            state_d = ST_LOAD;
          end else begin
            cmd_o.take = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + CntW'(1);
        if (cnt_q == CntW'(ScaleBits - 1)) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntW'(1);
        if (cnt_q == CntW'(ProdBits - 1)) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (side_q) begin
          state_d = ST_EMIT;
        end else begin
          side_d  = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_EMIT: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // A tick starts the speed unit on the left wheel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op_i == OP_TICK) |=> (state_q == ST_LOAD && !side_q))
    else $error("tick did not start the left wheel");

  // At most one datapath action per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.take, cmd_o.load, cmd_o.mul_step, cmd_o.div_step,
              cmd_o.store, cmd_o.finish}))
    else $error("overlapping datapath commands");

endmodule

@@ rtl/dqds_datapath.sv @@
// ----------------------------------------------------------------------------
// dqds_datapath
// Position counters, window snapshots, speed registers, configuration and a
// shared shift-add multiplier plus restoring divider for the speed.
// ----------------------------------------------------------------------------
module dqds_datapath import dqds_pkg::*; #(
  parameter int unsigned COUNT_BITS   = 32,
  parameter int unsigned WINDOW_SCALE = 100000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  cfg_idx_e           cfg_index_i,
  input  logic [CpmBits-1:0] cfg_data_i,
  input  op_e                op_i,
  input  logic [3:0]         phase_i,   // left A, left B, right A, right B
  input  cmd_t               cmd_i,
  output res_t               res_o
);

  localparam int unsigned ScaleBits = $clog2(WINDOW_SCALE + 1);
  localparam int unsigned ProdBits  = COUNT_BITS + ScaleBits;

  // Configuration
  logic [CpmBits-1:0] left_cpm_q, right_cpm_q;
  logic [1:0]         reverse_q;

  // Wheel state
  logic [1:0]                   left_prev_q, left_prev_d, right_prev_q, right_prev_d;
  logic signed [COUNT_BITS-1:0] left_cnt_q, left_cnt_d, right_cnt_q, right_cnt_d;
  logic signed [COUNT_BITS-1:0] left_snap_q, right_snap_q;
  logic [SpeedBits-1:0]         left_spd_q, left_spd_d, right_spd_q, right_spd_d;

  // Speed unit
  logic [COUNT_BITS-1:0] mag_q;
  logic                  neg_q, zero_q;
  logic [ScaleBits-1:0]  scale_q;
  logic [ProdBits-1:0]   acc_q;
  logic [CpmBits-1:0]    rem_q;
  logic [SpeedBits-1:0]  quo_q;
  logic                  sticky_q;

  logic [1:0]            left_cur, right_cur;
  step_e                 left_step, right_step;
  logic [COUNT_BITS-1:0] delta;
  logic                  delta_neg;
  logic [CpmBits-1:0]    divisor;
  logic [CpmBits:0]      rem_sh;
  logic                  fits;
  logic                  big;
  logic [SpeedBits-1:0]  speed_sat;
  logic signed [COUNT_BITS:0] pos_sum, pos_half;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cpm_q  <= CpmBits'(6896);
      right_cpm_q <= CpmBits'(6896);
      reverse_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LEFT_CPM:  left_cpm_q   <= cfg_data_i;
        CFG_RIGHT_CPM: right_cpm_q  <= cfg_data_i;
        CFG_LEFT_REV:  reverse_q[0] <= cfg_data_i[0];
        CFG_RIGHT_REV: reverse_q[1] <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign left_cur   = {phase_i[0], phase_i[1]};
  assign right_cur  = {phase_i[2], phase_i[3]};
  assign left_step  = step_of(left_prev_q, left_cur);
  assign right_step = step_of(right_prev_q, right_cur);

  // Saturate the quotient to a signed 32-bit speed
  assign big = sticky_q || quo_q[SpeedBits-1];
  always_comb begin
    if (zero_q) begin
      speed_sat = '0;
    end else if (neg_q) begin
      speed_sat = big ? {1'b1, {(SpeedBits-1){1'b0}}} : (SpeedBits'(0) - quo_q);
    end else begin
      speed_sat = big ? {1'b0, {(SpeedBits-1){1'b1}}} : quo_q;
    end
  end

  // Next counts, phases and speeds
  always_comb begin
    left_cnt_d   = left_cnt_q;
    right_cnt_d  = right_cnt_q;
    left_prev_d  = left_prev_q;
    right_prev_d = right_prev_q;
    left_spd_d   = left_spd_q;
    right_spd_d  = right_spd_q;
    if (cmd_i.take) begin
      unique case (op_i)
        OP_SAMPLE: begin
          left_prev_d  = left_cur;
          right_prev_d = right_cur;
          if (left_step == STEP_UP)    left_cnt_d  = left_cnt_q + COUNT_BITS'(1);
          if (left_step == STEP_DOWN)  left_cnt_d  = left_cnt_q - COUNT_BITS'(1);
          if (right_step == STEP_UP)   right_cnt_d = right_cnt_q + COUNT_BITS'(1);
          if (right_step == STEP_DOWN) right_cnt_d = right_cnt_q - COUNT_BITS'(1);
        end
        OP_CLEAR: begin
          left_cnt_d  = '0;
          right_cnt_d = '0;
          left_spd_d  = '0;
          right_spd_d = '0;
        end
        OP_TICK, OP_HOLD: ;
        default: ;
      endcase
    end
    if (cmd_i.store) begin
      if (cmd_i.side) right_spd_d = speed_sat;
      else            left_spd_d  = speed_sat;
    end
  end

  // Wheel state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_prev_q  <= '0;
      right_prev_q <= '0;
      left_cnt_q   <= '0;
      right_cnt_q  <= '0;
      left_snap_q  <= '0;
      right_snap_q <= '0;
      left_spd_q   <= '0;
      right_spd_q  <= '0;
    end else begin
      left_prev_q  <= left_prev_d;
      right_prev_q <= right_prev_d;
      left_cnt_q   <= left_cnt_d;
      right_cnt_q  <= right_cnt_d;
      left_spd_q   <= left_spd_d;
      right_spd_q  <= right_spd_d;
      if (cmd_i.finish) begin
        left_snap_q  <= left_cnt_q;
        right_snap_q <= right_cnt_q;
      end
    end
  end

  // Window delta of the selected wheel
  assign delta     = cmd_i.side ? COUNT_BITS'(right_cnt_q - right_snap_q)
                                : COUNT_BITS'(left_cnt_q - left_snap_q);
  assign delta_neg = delta[COUNT_BITS-1];
  assign divisor   = cmd_i.side ? right_cpm_q : left_cpm_q;

  // Restoring division step
  assign rem_sh = {rem_q, acc_q[ProdBits-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  // Speed unit: magnitude times scale, then divided by counts per metre
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q    <= delta_neg ? (COUNT_BITS'(0) - delta) : delta;
      neg_q    <= delta_neg ^ reverse_q[cmd_i.side];
      zero_q   <= (delta == '0);
      scale_q  <= ScaleBits'(WINDOW_SCALE);
      acc_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      sticky_q <= 1'b0;
    end else if (cmd_i.mul_step) begin
      scale_q <= scale_q << 1;
      acc_q   <= (acc_q << 1) + (scale_q[ScaleBits-1] ? ProdBits'(mag_q) : '0);
    end else if (cmd_i.div_step) begin
      acc_q    <= acc_q << 1;
      rem_q    <= fits ? CpmBits'(rem_sh - {1'b0, divisor}) : rem_sh[CpmBits-1:0];
      quo_q    <= {quo_q[SpeedBits-2:0], fits};
      sticky_q <= sticky_q || quo_q[SpeedBits-1];
    end
  end

  // Mean of both counts, truncated toward zero
  assign pos_sum  = {left_cnt_d[COUNT_BITS-1], left_cnt_d}
                  + {right_cnt_d[COUNT_BITS-1], right_cnt_d};
  assign pos_half = (pos_sum >>> 1)
                  + $signed({{COUNT_BITS{1'b0}}, pos_sum[COUNT_BITS] & pos_sum[0]});

  // Result from the state after this command
  assign res_o.done        = cmd_i.finish;
  assign res_o.left_pos    = 32'(left_cnt_d);
  assign res_o.right_pos   = 32'(right_cnt_d);
  assign res_o.left_speed  = left_spd_d;
  assign res_o.right_speed = right_spd_d;
  assign res_o.mean_pos    = 32'(pos_half);

  // Snapshots follow the counts once a window closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (left_snap_q == $past(left_cnt_q) &&
                      right_snap_q == $past(right_cnt_q)))
    else $error("window snapshot lost");

endmodule

@@ rtl/dqds_obuf.sv @@
// ----------------------------------------------------------------------------
// dqds_obuf
// Two-entry result buffer: output register plus skid register, so that one
// result may be produced while the previous one is still stalled.
// ----------------------------------------------------------------------------
module dqds_obuf import dqds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic free_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic out_open;

  assign out_open    = !out_valid_q || out_ready_i;
  assign free_o      = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_open) begin
        out_valid_q  <= push_i || skid_valid_q;
        skid_valid_q <= 1'b0;
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload: refill the output from the skid first, park a push when stalled
  always_ff @(posedge clk_i) begin
    if (out_open) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  // A push must never meet a full skid register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed into a full buffer");

endmodule
